// ===== design/apafb_pkg.sv =====
// apafb_pkg: shared types, constants and helpers for the APA102 frame builder.
// Used by apafb_ctrl, apafb_dp and apa102_frame_builder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package apafb_pkg;

	localparam int MAX_LEDS  = 16;
	localparam int IDX_W     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CNT_W     = $clog2(MAX_LEDS + 1);
	localparam int LCNT_W    = 5;
	localparam int END_WORDS = 8;
	localparam int END_CNT_W = $clog2(END_WORDS);

	localparam logic [LCNT_W-1:0] LED_COUNT_RST = LCNT_W'(12);
	localparam logic [31:0]       START_WORD    = 32'h0000_0000;
	localparam logic [31:0]       END_WORD      = 32'h0101_0101;
	localparam logic [7:0]        LED_HEADER    = 8'hFF;

	typedef enum logic [1:0] {
		MODE_RGB    = 2'd0,
		MODE_SCALED = 2'd1,
		MODE_SHOW   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_START,
		ST_LEDS,
		ST_END
	} state_t;

	typedef enum logic [1:0] {
		SEL_START,
		SEL_LED,
		SEL_END
	} sel_t;

	// controller -> datapath
	typedef struct packed {
		logic             wr_rgb;
		logic             mul_load;
		logic             wr_scaled;
		logic             clr;
		logic             emit;
		sel_t             sel;
		logic             last;
		logic [IDX_W-1:0] led_addr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNT_W-1:0] active;
	} status_t;

	// exact x/255 for any 16-bit product of two bytes
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// ===== design/apa102_frame_builder.sv =====
// APA102 strip frame builder: usage notes below.
// Start/busy command port in, one-cycle strobed word stream out.
// Channels: a command is taken at a clock edge where start is high and busy
//   is low; mode picks write RGB, write scaled packed color, show or clear.
// Config: cfg_we/cfg_wdata set led_count (reset 12, above 16 acts as 16);
//   write it only while no show is running.
// Writes: an RGB write takes effect at the accepting edge, busy stays low.
//   A scaled write first registers the three channel*level products, then
//   divides them by 255 and stores them; busy is high for 1 cycle.
// Show/clear: busy during the frame (n = active LEDs); the start word appears
//   the cycle after the first busy cycle, then one word per cycle: n LED
//   words, eight end words, last_word on the final one. One word per clock
//   is set by the single store read port walked by the LED counter.
//   Clear zeroes the active entries at the accepting edge, then shows.
// Output: word_valid marks frame_word/last_word for exactly one cycle; the
//   receiver has no back-pressure.
// Reset: asynchronous; the color store is zeroed and led_count goes to 12.
// Depends on apafb_pkg, apafb_ctrl, apafb_dp.
`timescale 1ns / 1ps
`default_nettype none

module apa102_frame_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  led_index,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [31:0] packed_color,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	output logic [31:0]      frame_word,
	output logic             last_word,
	output logic             word_valid
);

	apafb_pkg::cmd_t    cmd;
	apafb_pkg::status_t sts;

	apafb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	apafb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.led_index    (led_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.packed_color (packed_color),
		.frame_word   (frame_word),
		.last_word    (last_word),
		.word_valid   (word_valid)
	);

endmodule

`default_nettype wire

// ===== design/apafb_ctrl.sv =====
// apafb_ctrl: sequencer for writes, shows and clears of the frame builder.
// Depends on apafb_pkg; drives apafb_dp through cmd_t, reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module apafb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         mode,
	input  wire apafb_pkg::status_t sts,
	output apafb_pkg::cmd_t         cmd,
	output logic                    busy
);

	apafb_pkg::state_t                    state_q, state_d;
	logic [apafb_pkg::IDX_W-1:0]          led_q;
	logic [apafb_pkg::END_CNT_W-1:0]      end_q;
	apafb_pkg::mode_t                     mode_in;
	logic                                 led_last;
	logic                                 end_last;

	assign mode_in  = apafb_pkg::mode_t'(mode);
	assign led_last = (32'(led_q) + 32'd1) >= 32'(sts.active);
	assign end_last = (end_q == apafb_pkg::END_CNT_W'(apafb_pkg::END_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apafb_pkg::ST_IDLE;
			led_q   <= '0;
			end_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == apafb_pkg::ST_LEDS)
				led_q <= led_q + 1'b1;
			else
				led_q <= '0;
			if (state_q == apafb_pkg::ST_END)
				end_q <= end_q + 1'b1;
			else
				end_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			apafb_pkg::ST_IDLE: begin
				if (start) begin
					case (mode_in)
						apafb_pkg::MODE_SCALED: state_d = apafb_pkg::ST_SCALE;
						apafb_pkg::MODE_SHOW,
						apafb_pkg::MODE_CLEAR:  state_d = apafb_pkg::ST_START;
						default:                state_d = apafb_pkg::ST_IDLE;
					endcase
				end
			end
			apafb_pkg::ST_SCALE: state_d = apafb_pkg::ST_IDLE;
			apafb_pkg::ST_START: begin
				if (sts.active == '0)
					state_d = apafb_pkg::ST_END;
				else
					state_d = apafb_pkg::ST_LEDS;
			end
			apafb_pkg::ST_LEDS: begin
				if (led_last)
					state_d = apafb_pkg::ST_END;
			end
			apafb_pkg::ST_END: begin
				if (end_last)
					state_d = apafb_pkg::ST_IDLE;
			end
			default: state_d = apafb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.sel      = apafb_pkg::SEL_START;
		cmd.led_addr = led_q;
		busy         = 1'b1;
		case (state_q)
			apafb_pkg::ST_IDLE: begin
				busy         = 1'b0;
				cmd.wr_rgb   = start && (mode_in == apafb_pkg::MODE_RGB);
				cmd.mul_load = start && (mode_in == apafb_pkg::MODE_SCALED);
				cmd.clr      = start && (mode_in == apafb_pkg::MODE_CLEAR);
			end
			apafb_pkg::ST_SCALE: cmd.wr_scaled = 1'b1;
			apafb_pkg::ST_START: begin
				cmd.emit = 1'b1;
				cmd.sel  = apafb_pkg::SEL_START;
			end
			apafb_pkg::ST_LEDS: begin
				cmd.emit = 1'b1;
				cmd.sel  = apafb_pkg::SEL_LED;
			end
			apafb_pkg::ST_END: begin
				cmd.emit = 1'b1;
				cmd.sel  = apafb_pkg::SEL_END;
				cmd.last = end_last;
			end
			default: busy = 1'b1;
		endcase
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_rgb, cmd.mul_load, cmd.wr_scaled, cmd.clr, cmd.emit}))
		else $error("conflicting datapath commands");

	a_show_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode_in == apafb_pkg::MODE_SHOW || mode_in == apafb_pkg::MODE_CLEAR)
		|=> busy && state_q == apafb_pkg::ST_START)
		else $error("show not started");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apafb_pkg::ST_END && end_last |=> !busy)
		else $error("frame did not finish after last end word");

	a_scale_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_scaled |-> $past(cmd.mul_load))
		else $error("scaled write without product load");

endmodule

`default_nettype wire

// ===== design/apafb_dp.sv =====
// apafb_dp: color store, level scaling, count register and frame word output.
// Depends on apafb_pkg; commanded by apafb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module apafb_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire apafb_pkg::cmd_t             cmd,
	output apafb_pkg::status_t               sts,
	input  wire logic                        cfg_we,
	input  wire logic [apafb_pkg::LCNT_W-1:0] cfg_wdata,
	input  wire logic [7:0]                  led_index,
	input  wire logic [7:0]                  red,
	input  wire logic [7:0]                  green,
	input  wire logic [7:0]                  blue,
	input  wire logic [31:0]                 packed_color,
	output logic [31:0]                      frame_word,
	output logic                             last_word,
	output logic                             word_valid
);

	logic [apafb_pkg::LCNT_W-1:0] led_count_q;
	logic [apafb_pkg::CNT_W-1:0]  active;
	logic [23:0]                  store_q [apafb_pkg::MAX_LEDS];
	logic [15:0]                  prod_r_q, prod_g_q, prod_b_q;
	logic [7:0]                   idx_q;
	logic                         idx_ok, idx_ok_q;
	logic [23:0]                  rd;
	logic [31:0]                  word_d;
	logic [31:0]                  word_q;
	logic                         last_q, valid_q;

	assign active = (32'(led_count_q) > 32'(apafb_pkg::MAX_LEDS))
		? apafb_pkg::CNT_W'(apafb_pkg::MAX_LEDS) : apafb_pkg::CNT_W'(led_count_q);
	assign sts.active = active;
	assign idx_ok     = 32'(led_index) < 32'(active);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			led_count_q <= apafb_pkg::LED_COUNT_RST;
		else if (cfg_we)
			led_count_q <= cfg_wdata;
	end

	// products registered before the /255 correction
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			prod_r_q <= 16'(packed_color[31:24]) * 16'(packed_color[7:0]);
			prod_g_q <= 16'(packed_color[23:16]) * 16'(packed_color[7:0]);
			prod_b_q <= 16'(packed_color[15:8]) * 16'(packed_color[7:0]);
			idx_q    <= led_index;
			idx_ok_q <= idx_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < apafb_pkg::MAX_LEDS; i++)
				store_q[i] <= '0;
		end else if (cmd.clr) begin
			for (int i = 0; i < apafb_pkg::MAX_LEDS; i++)
				if (i < 32'(active))
					store_q[i] <= '0;
		end else if (cmd.wr_rgb && idx_ok) begin
			store_q[led_index[apafb_pkg::IDX_W-1:0]] <= {red, green, blue};
		end else if (cmd.wr_scaled && idx_ok_q) begin
			store_q[idx_q[apafb_pkg::IDX_W-1:0]] <= {apafb_pkg::div255(prod_r_q),
				apafb_pkg::div255(prod_g_q), apafb_pkg::div255(prod_b_q)};
		end
	end

	assign rd = store_q[cmd.led_addr];

	always_comb begin
		case (cmd.sel)
			apafb_pkg::SEL_START: word_d = apafb_pkg::START_WORD;
			apafb_pkg::SEL_LED:   word_d = {apafb_pkg::LED_HEADER, rd[7:0], rd[15:8], rd[23:16]};
			apafb_pkg::SEL_END:   word_d = apafb_pkg::END_WORD;
			default:              word_d = apafb_pkg::START_WORD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			last_q  <= cmd.emit && cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			word_q <= word_d;
	end

	assign frame_word = word_q;
	assign last_word  = last_q;
	assign word_valid = valid_q;

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> valid_q && word_q == apafb_pkg::END_WORD)
		else $error("last flag on a word that is not an end word");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> valid_q)
		else $error("emitted word did not reach the output");

endmodule

`default_nettype wire
